/* sv/ilcr_pkg.sv */
// ----------------------------------------------------------------------------
// ilcr_pkg
// Shared types and constants for the indexed list with compacting remove.
// ----------------------------------------------------------------------------
package ilcr_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 64;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_SET    = 3'd1,
    CMD_GET    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [ADDR_W-1:0] position;
    logic [DATA_W-1:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] value_out;
    logic [CNT_W-1:0]  count;
    logic [1:0]        status;
  } out_word_t;

endpackage

/* sv/ilcr_ram.sv */
// ----------------------------------------------------------------------------
// ilcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/indexed_list_with_compacting_remove.sv */
// ----------------------------------------------------------------------------
// indexed_list_with_compacting_remove
// Fixed-capacity ordered list of 64-bit words with append, set, get,
// compacting remove and clear.
// ----------------------------------------------------------------------------
// usage:
//   a command word is taken when start is high and busy is low. each command
//   gives exactly one result word, shown for one cycle with out_valid high.
//   append, set, clear, unknown codes and any bad index finish in the accept
//   cycle: the result is registered for the next cycle, busy stays low, so these
//   run at one word per cycle.
//   get reads the entry store, whose read data is registered: busy is high
//   in the S_GET state, and the result word is registered from the read data.
//   remove at position p with n entries in use walks the store one entry per
//   cycle while busy is high, and the result is registered once the walk ends
//   (removing the last entry finishes in the accept cycle like append).
//   the walk through the single-port-pair entry RAM sets the remove time.
//   reset clears the count and control state; the store is not cleared.
//   the receiver cannot stall: out_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module indexed_list_with_compacting_remove (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ilcr_pkg::in_word_t  in_word,
  output logic                out_valid,
  output ilcr_pkg::out_word_t out_word
);

  import ilcr_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              pos_ok;
  logic [CNT_W-1:0]  pos_ext;
  logic [CNT_W-1:0]  idx_plus2;

  ilcr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign pos_ext   = {1'b0, in_word.position};
  assign pos_ok    = pos_ext < count_r;
  assign idx_plus2 = {1'b0, idx_r} + CNT_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = in_word.position;
    mem_wdata     = in_word.value_in;
    mem_raddr     = in_word.position;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt     = 1'b1;
          out_nxt.value_out = '0;
          out_nxt.status    = ST_OK;
          case (in_word.command)
            CMD_APPEND: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                out_nxt.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[ADDR_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_SET: begin
              if (pos_ok) begin
                mem_we = 1'b1;
              end else begin
                out_nxt.status = ST_BAD_INDEX;
              end
            end
            CMD_GET: begin
              if (pos_ok) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_GET;
              end else begin
                out_nxt.status = ST_BAD_INDEX;
              end
            end
            CMD_REMOVE: begin
              if (!pos_ok) begin
                out_nxt.status = ST_BAD_INDEX;
              end else if (pos_ext + CNT_W'(1) == count_r) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                out_valid_nxt = 1'b0;
                mem_raddr     = in_word.position + ADDR_W'(1);
                idx_nxt       = in_word.position;
                state_nxt     = S_SHIFT;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          out_nxt.count = count_nxt;
        end
      end
      S_GET: begin
        out_valid_nxt     = 1'b1;
        out_nxt.value_out = mem_rdata;
        out_nxt.count     = count_r;
        out_nxt.status    = ST_OK;
        state_nxt         = S_IDLE;
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        mem_raddr = idx_plus2[ADDR_W-1:0];
        if (idx_plus2 < count_r) begin
          idx_nxt = idx_r + ADDR_W'(1);
        end else begin
          count_nxt         = count_r - CNT_W'(1);
          out_valid_nxt     = 1'b1;
          out_nxt.value_out = '0;
          out_nxt.count     = count_r - CNT_W'(1);
          out_nxt.status    = ST_OK;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while busy");

  a_shift_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> {1'b0, mem_waddr} + CNT_W'(1) < count_r)
    else $error("shift write outside the list");

  a_full_means_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_FULL |-> out_r.count == CNT_W'(CAPACITY))
    else $error("full flagged below capacity");

  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GET |=> out_valid_r && state_r == S_IDLE)
    else $error("get result missing");

endmodule
